@@ sv/hdc_pkg.sv @@
// ============================================================================
// hdc_pkg - shared types and constants for the homophonic digit codec
// Field widths, operation and result codes, the command queue entry and the
// clamped configuration bundle passed from the front end to the back end.
// ============================================================================
package hdc_pkg;

  localparam int MAX_DIGITS   = 8;
  localparam int MAX_VARIANTS = 16;
  localparam int DIGIT_ROWS   = 10;
  localparam int ENTRIES      = DIGIT_ROWS * MAX_VARIANTS;
  localparam int ADDR_W       = $clog2(ENTRIES);

  // Field widths
  localparam int OP_W   = 2;
  localparam int DIG_W  = 4;
  localparam int VAR_W  = 4;
  localparam int BYTE_W = 8;
  localparam int NUM_W  = 27;
  localparam int CHO_W  = 32;
  localparam int KIND_W = 2;

  // Configuration register widths
  localparam int DCFG_W     = 4;
  localparam int LCFG_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_FIELDS_W  = DIG_W + VAR_W + BYTE_W + NUM_W + CHO_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = BYTE_W + NUM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Digit counters
  localparam int CNT_W = $clog2(MAX_DIGITS);
  localparam int POS_W = 4;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Division by ten through a reciprocal, exact for any 27-bit dividend
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTERS = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ENCODE,
    CMD_REJECT,
    CMD_DECODE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DIG_W-1:0]  digit;
    logic [VAR_W-1:0]  variant;
    logic [BYTE_W-1:0] data_byte;
    logic [NUM_W-1:0]  number;
    logic [CHO_W-1:0]  choices;
  } qent_t;

  typedef struct packed {
    logic [DCFG_W-1:0] digits;   // 1..MAX_DIGITS
    logic [LCFG_W-1:0] letters;  // 1..MAX_VARIANTS
  } cfg_t;

endpackage

@@ sv/homophonic_digit_codec_top.sv @@
// ============================================================================
// homophonic_digit_codec_top - homophonic substitution codec for digits
// Flow: each accepted command passes through the queue to the back end. A write
//   lands in the table when it is popped; a decode passes a match step and a
//   digit step (and a result step when it yields a result); an encode runs d
//   divide-by-ten steps, then a memory read and an output load per byte, d
//   being the clamped digit count. Result stalls hold the back end; a 4-deep
//   queue lets input run ahead meanwhile.
// Reset: synchronous, active low; clears the queue, the decode accumulator
//   and position, sets both registers to 1. Table contents are kept as is.
// ============================================================================
module homophonic_digit_codec_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] table_digit, [7:4] table_variant, [15:8] byte_in,
  // [42:16] number_in, [74:43] variant_choices, [79:75] zero
  input  logic [hdc_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [hdc_pkg::OP_W-1:0]         in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] byte_out, [34:8] number_out, [39:35] zero
  output logic [hdc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] result_kind
  output logic [hdc_pkg::KIND_W-1:0]       out_tuser,
  // last result of the input transaction
  output logic                             out_tlast
);
  import hdc_pkg::*;

  // Front end to queue
  logic  q_push;
  qent_t q_ent;
  logic  q_full;

  // Queue to back end
  logic  q_valid;
  logic  q_pop;
  qent_t q_head;

  // Clamped configuration; the user keeps it stable whenever commands are in flight (not enforced)
  cfg_t  cfg;

  // Accept and classify transactions, hold the registers
  hdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (q_ent),
    .cfg       (cfg)
  );

  // Decouple the two sides so each can stall on its own
  hdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Execute commands and drive the registered result stream
  hdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ sv/hdc_front.sv @@
// ============================================================================
// hdc_front - input acceptance, classification and configuration
// Holds the configuration registers, checks each input transaction against
// them and pushes a classified command into the queue.
// ============================================================================
module hdc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hdc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [hdc_pkg::OP_W-1:0]         in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output hdc_pkg::qent_t                   q_ent,
  output hdc_pkg::cfg_t                    cfg
);
  import hdc_pkg::*;

  logic [DCFG_W-1:0] digits_r, digits_nxt;
  logic [LCFG_W-1:0] letters_r, letters_nxt;
  logic [DCFG_W-1:0] dcount;
  logic [LCFG_W-1:0] lcount;
  logic              accept;
  logic              too_big;
  logic              slice_bad;
  logic [VAR_W-1:0]  slice;
  logic [NUM_W-1:0]  pow_lim;
  cmd_t              cmd;

  always_comb begin
    digits_nxt  = digits_r;
    letters_nxt = letters_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIGITS:  digits_nxt  = cfg_wdata[DCFG_W-1:0];
        CFG_LETTERS: letters_nxt = cfg_wdata[LCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r  <= DCFG_W'(1);
      letters_r <= LCFG_W'(1);
    end else begin
      digits_r  <= digits_nxt;
      letters_r <= letters_nxt;
    end
  end

  // Clamp to the supported ranges
  always_comb begin
    if (digits_r == '0)                        dcount = DCFG_W'(1);
    else if (digits_r > DCFG_W'(MAX_DIGITS))   dcount = DCFG_W'(MAX_DIGITS);
    else                                       dcount = digits_r;
    if (letters_r == '0)                       lcount = LCFG_W'(1);
    else if (letters_r > LCFG_W'(MAX_VARIANTS)) lcount = LCFG_W'(MAX_VARIANTS);
    else                                       lcount = letters_r;
  end

  assign cfg.digits  = dcount;
  assign cfg.letters = lcount;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Unpack the payload
  assign q_ent.digit     = in_tdata[DIG_W-1:0];
  assign q_ent.variant   = in_tdata[DIG_W +: VAR_W];
  assign q_ent.data_byte = in_tdata[DIG_W+VAR_W +: BYTE_W];
  assign q_ent.number    = in_tdata[DIG_W+VAR_W+BYTE_W +: NUM_W];
  assign q_ent.choices   = in_tdata[DIG_W+VAR_W+BYTE_W+NUM_W +: CHO_W];
  assign q_ent.cmd       = cmd;

  // Smallest number that no longer fits in the digits in use
  always_comb begin
    unique case (dcount)
      4'd1:    pow_lim = 27'd10;
      4'd2:    pow_lim = 27'd100;
      4'd3:    pow_lim = 27'd1000;
      4'd4:    pow_lim = 27'd10000;
      4'd5:    pow_lim = 27'd100000;
      4'd6:    pow_lim = 27'd1000000;
      4'd7:    pow_lim = 27'd10000000;
      default: pow_lim = 27'd100000000;
    endcase
  end

  assign too_big = (q_ent.number >= pow_lim);

  // Any variant slice in use that points past the letters in use
  always_comb begin
    slice_bad = 1'b0;
    slice     = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      slice = q_ent.choices[VAR_W*i +: VAR_W];
      if ((i < int'(dcount)) && ({1'b0, slice} >= lcount)) slice_bad = 1'b1;
    end
  end

  // Classify; drop writes off the table and unknown operations
  always_comb begin
    q_push = 1'b0;
    cmd    = CMD_WRITE;
    unique case (in_tuser)
      OP_WRITE: begin
        cmd    = CMD_WRITE;
        q_push = accept && (q_ent.digit < DIG_W'(DIGIT_ROWS))
                 && ({1'b0, q_ent.variant} < (VAR_W+1)'(MAX_VARIANTS));
      end
      OP_ENCODE: begin
        cmd    = (too_big || slice_bad) ? CMD_REJECT : CMD_ENCODE;
        q_push = accept;
      end
      OP_DECODE: begin
        cmd    = CMD_DECODE;
        q_push = accept;
      end
      default: q_push = 1'b0;
    endcase
  end

endmodule

@@ sv/hdc_queue.sv @@
// ============================================================================
// hdc_queue - command queue between front end and back end
// Short first-in first-out buffer of classified commands.
// ============================================================================
module hdc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hdc_pkg::qent_t push_ent,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output hdc_pkg::qent_t head
);
  import hdc_pkg::*;

  qent_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ent;
  end

endmodule

@@ sv/hdc_back.sv @@
// ============================================================================
// hdc_back - command execution and result register
// Owns the variant table, converts numbers to digits, emits encoded bytes,
// matches decode bytes and drives the result stream.
// ============================================================================
module hdc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  hdc_pkg::qent_t                 q_head,
  output logic                           q_pop,
  input  hdc_pkg::cfg_t                  cfg,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hdc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [hdc_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import hdc_pkg::*;

  localparam int PROD_W = NUM_W + 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_MATCH = 7'b0010000,
    S_DEC   = 7'b0100000,
    S_PUT   = 7'b1000000
  } bst_t;

  bst_t               state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   conv_n_r, conv_n_nxt;
  logic [CHO_W-1:0]   choices_r, choices_nxt;
  logic [BYTE_W-1:0]  dbyte_r, dbyte_nxt;
  logic [DIG_W-1:0]   digits_r [MAX_DIGITS];
  logic [DIGIT_ROWS-1:0] hit_r, hit_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [KIND_W-1:0]  pend_kind_r, pend_kind_nxt;
  logic [NUM_W-1:0]   pend_num_r, pend_num_nxt;

  logic [BYTE_W-1:0]  tab_r [DIGIT_ROWS][MAX_VARIANTS];
  logic [BYTE_W-1:0]  ram [ENTRIES];
  logic [BYTE_W-1:0]  ram_q_r;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [NUM_W-1:0]   out_num_r;
  logic               out_last_r;

  logic               tab_we, rd_en, dig_we;
  logic               ld, ld_last;
  logic [KIND_W-1:0]  ld_kind;
  logic [BYTE_W-1:0]  ld_byte;
  logic [NUM_W-1:0]   ld_num;
  logic               out_free;

  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   quot, quot10;
  logic [DIG_W-1:0]   rem;
  logic [DCFG_W-1:0]  emit_idx;
  logic [VAR_W-1:0]   var_sel;
  logic               last_dig;
  logic [DIGIT_ROWS-1:0] row_hit;
  logic               found;
  logic [DIG_W-1:0]   row;
  logic [NUM_W-1:0]   acc_new;
  logic [POS_W-1:0]   pos_inc;

  // Divide by ten through the reciprocal; remainder is the next digit
  assign prod   = PROD_W'(conv_n_r) * PROD_W'(RECIP_TEN);
  assign quot   = NUM_W'(prod >> RECIP_SHIFT);
  assign quot10 = (quot << 3) + (quot << 1);
  assign rem    = DIG_W'(conv_n_r - quot10);

  // Emit most significant digit first
  assign emit_idx = cfg.digits - DCFG_W'(1) - DCFG_W'(cnt_r);
  assign var_sel  = choices_r[VAR_W*cnt_r +: VAR_W];
  assign last_dig = (DCFG_W'(cnt_r) == cfg.digits - DCFG_W'(1));
  assign rd_addr  = ADDR_W'(digits_r[emit_idx[CNT_W-1:0]]) * ADDR_W'(MAX_VARIANTS)
                    + ADDR_W'(var_sel);
  assign wr_addr  = ADDR_W'(q_head.digit) * ADDR_W'(MAX_VARIANTS)
                    + ADDR_W'(q_head.variant);

  // Parallel match, one compare per table entry
  always_comb begin
    row_hit = '0;
    for (int r = 0; r < DIGIT_ROWS; r++) begin
      for (int v = 0; v < MAX_VARIANTS; v++) begin
        if ((v < int'(cfg.letters)) && (tab_r[r][v] == dbyte_r)) row_hit[r] = 1'b1;
      end
    end
  end

  // Lowest matching digit wins
  always_comb begin
    found = 1'b0;
    row   = '0;
    for (int r = DIGIT_ROWS - 1; r >= 0; r--) begin
      if (hit_r[r]) begin
        found = 1'b1;
        row   = DIG_W'(r);
      end
    end
  end

  assign acc_new  = (acc_r << 3) + (acc_r << 1) + NUM_W'(row);
  assign pos_inc  = pos_r + 1'b1;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    conv_n_nxt    = conv_n_r;
    choices_nxt   = choices_r;
    dbyte_nxt     = dbyte_r;
    hit_nxt       = hit_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    pend_kind_nxt = pend_kind_r;
    pend_num_nxt  = pend_num_r;
    q_pop         = 1'b0;
    tab_we        = 1'b0;
    rd_en         = 1'b0;
    dig_we        = 1'b0;
    ld            = 1'b0;
    ld_kind       = KIND_BYTE;
    ld_byte       = '0;
    ld_num        = '0;
    ld_last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_head.cmd)
            CMD_WRITE: tab_we = 1'b1;
            CMD_ENCODE: begin
              conv_n_nxt  = q_head.number;
              choices_nxt = q_head.choices;
              cnt_nxt     = '0;
              state_nxt   = S_CONV;
            end
            CMD_REJECT: begin
              pend_kind_nxt = KIND_ERROR;
              pend_num_nxt  = '0;
              state_nxt     = S_PUT;
            end
            CMD_DECODE: begin
              dbyte_nxt = q_head.data_byte;
              state_nxt = S_MATCH;
            end
            default: ;
          endcase
        end
      end
      S_CONV: begin
        dig_we     = 1'b1;
        conv_n_nxt = quot;
        if (last_dig) begin
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = KIND_BYTE;
          ld_byte = ram_q_r;
          ld_last = last_dig;
          if (last_dig) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_MATCH: begin
        hit_nxt   = row_hit;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!found) begin
          acc_nxt       = '0;
          pos_nxt       = '0;
          pend_kind_nxt = KIND_ERROR;
          pend_num_nxt  = '0;
          state_nxt     = S_PUT;
        end else if (pos_inc >= POS_W'(cfg.digits)) begin
          acc_nxt       = '0;
          pos_nxt       = '0;
          pend_kind_nxt = KIND_NUMBER;
          pend_num_nxt  = acc_new;
          state_nxt     = S_PUT;
        end else begin
          acc_nxt   = acc_new;
          pos_nxt   = pos_inc;
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = pend_kind_r;
          ld_num    = pend_num_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (ld)                        out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    conv_n_r    <= conv_n_nxt;
    choices_r   <= choices_nxt;
    dbyte_r     <= dbyte_nxt;
    hit_r       <= hit_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_num_r  <= pend_num_nxt;
    if (dig_we) digits_r[cnt_r] <= rem;
    if (ld) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_num_r  <= ld_num;
      out_last_r <= ld_last;
    end
  end

  // Match copy in flops, encode copy in memory; both written together
  always_ff @(posedge clk) begin
    if (tab_we) tab_r[q_head.digit][q_head.variant] <= q_head.data_byte;
  end

  always_ff @(posedge clk) begin
    if (tab_we) ram[wr_addr] <= q_head.data_byte;
    if (rd_en)  ram_q_r <= ram[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_FIELDS_W)'(0), out_num_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < POS_W'(MAX_DIGITS))
    else $error("decode position ran past the largest digit count");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_ERROR) |-> out_last_r && (out_num_r == '0))
    else $error("error result without last or with a number");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_BYTE) |-> (out_num_r == '0))
    else $error("encoded byte result carries a number");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_EMIT) |-> $past(state_r == S_RD))
    else $error("byte emitted without a table read");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (rd_addr < ADDR_W'(ENTRIES)))
    else $error("encode read beyond the table");
`endif

endmodule

@@ tb/hdc_checker.sv @@
// ----------------------------------------------------------------------------
// hdc_checker - result predictor and scoreboard for the homophonic digit codec
// Watches the configuration port and both streams. For every input
// transaction it predicts the results from its own copy of the table,
// registers and decode state, then compares each result transaction in order.
// ----------------------------------------------------------------------------
module hdc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hdc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [hdc_pkg::OP_W-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hdc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [hdc_pkg::KIND_W-1:0]     out_tuser,
  input  logic                           out_tlast,
  output int                             mismatches,
  output int                             results_due
);
  import hdc_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] cipher;
    logic [NUM_W-1:0]  number;
    logic              last;
  } codec_result_t;

  codec_result_t     awaited_results[$];
  logic [BYTE_W-1:0] key_table [ENTRIES];
  logic [NUM_W-1:0]  digit_acc;
  logic [POS_W-1:0]  digit_pos;
  logic [DCFG_W-1:0] digits_reg;
  logic [LCFG_W-1:0] letters_reg;
  int                mismatch_count;

  task automatic await_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                              input logic [NUM_W-1:0] n, input logic last);
    codec_result_t r;
    r.kind   = kind;
    r.cipher = b;
    r.number = n;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  task automatic predict_codec_results(input logic [OP_W-1:0] op,
                                       input logic [IN_DATA_W-1:0] data);
    logic [DIG_W-1:0]  row;
    logic [VAR_W-1:0]  col;
    logic [BYTE_W-1:0] b;
    logic [NUM_W-1:0]  num;
    logic [CHO_W-1:0]  cho;
    logic [3:0]        digs [MAX_DIGITS];
    int unsigned       d, l, rem;
    longint            span;
    bit                bad, found;
    int                hit;
    row  = data[3:0];
    col  = data[7:4];
    b    = data[15:8];
    num  = data[42:16];
    cho  = data[74:43];
    d    = (digits_reg == 0) ? 1 : ((digits_reg > MAX_DIGITS) ? MAX_DIGITS : digits_reg);
    l    = (letters_reg == 0) ? 1 : ((letters_reg > MAX_VARIANTS) ? MAX_VARIANTS : letters_reg);
    span = 1;
    repeat (d) span = span * 10;
    bad   = 1'b0;
    found = 1'b0;
    hit   = 0;
    case (op)
      OP_WRITE: begin
        // out-of-range rows are dropped
        if (row < DIGIT_ROWS) key_table[row * MAX_VARIANTS + col] = b;
      end
      OP_ENCODE: begin
        for (int i = 0; i < d; i++) if (cho[4*i +: 4] >= l) bad = 1'b1;
        if (num > span - 1 || bad) begin
          await_result(KIND_ERROR, '0, '0, 1'b1);
        end else begin
          rem = 32'(num);
          for (int k = d - 1; k >= 0; k--) begin
            digs[k] = 4'(rem % 10);
            rem     = rem / 10;
          end
          for (int i = 0; i < d; i++)
            await_result(KIND_BYTE, key_table[digs[i] * MAX_VARIANTS + cho[4*i +: 4]], '0,
                         (i == d - 1));
        end
      end
      OP_DECODE: begin
        // lowest digit first, lowest variant first within a digit
        for (int r = 0; r < DIGIT_ROWS && !found; r++)
          for (int c = 0; c < l && !found; c++)
            if (key_table[r * MAX_VARIANTS + c] == b) begin
              found = 1'b1;
              hit   = r;
            end
        if (!found) begin
          digit_acc = '0;
          digit_pos = '0;
          await_result(KIND_ERROR, '0, '0, 1'b1);
        end else begin
          digit_acc = NUM_W'(digit_acc * 10 + hit);
          digit_pos = digit_pos + 1'b1;
          if (digit_pos >= d) begin
            await_result(KIND_NUMBER, '0, digit_acc, 1'b1);
            digit_acc = '0;
            digit_pos = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag(input string field, input longint want, input longint got);
    mismatch_count++;
    $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    codec_result_t want;
    if (!rst_n) begin
      digit_acc   = '0;
      digit_pos   = '0;
      digits_reg  = DCFG_W'(1);
      letters_reg = LCFG_W'(1);
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d data 0x%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser != want.kind)
            flag("result_kind", longint'(want.kind), longint'(out_tuser));
          if (out_tdata[7:0] != want.cipher)
            flag("byte_out", longint'(want.cipher), longint'(out_tdata[7:0]));
          if (out_tdata[34:8] != want.number)
            flag("number_out", longint'(want.number), longint'(out_tdata[34:8]));
          if (out_tlast != want.last)
            flag("last", longint'(want.last), longint'(out_tlast));
        end
      end
      // a transaction taken at this edge still sees the old registers
      if (in_tvalid && in_tready) predict_codec_results(in_tuser, in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIGITS:  digits_reg  = cfg_wdata[DCFG_W-1:0];
          CFG_LETTERS: letters_reg = cfg_wdata[LCFG_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= mismatch_count;
    results_due <= awaited_results.size();
  end

endmodule

@@ tb/tb_homophonic_digit_codec_top.sv @@
// ----------------------------------------------------------------------------
// tb_homophonic_digit_codec_top - stimulus and verdict for the digit codec
// Loads the whole variant table, runs a directed set of corner cases, then
// random phases under several digit and letter counts. Both stream sides
// idle at random except in the closing phase; a separate checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_homophonic_digit_codec_top;
  import hdc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // no such operation, must be ignored
  localparam int RANDOM_ITEMS = 120;
  localparam int PHASES       = 7;
  // a few queued writes and silent decodes may still be in flight after the
  // last result has left
  localparam int SETTLE_CYCLES = 48;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  int                    check_failures;
  int                    results_due;

  // stimulus-side view of the table and the clamped counts, used only to
  // build well-formed transactions
  logic [BYTE_W-1:0] cipher_shadow [ENTRIES];
  int unsigned       cur_digits  = 1;
  int unsigned       cur_letters = 1;
  bit                idling_on   = 1'b1;
  int                random_items = 0;

  always #5 clk = ~clk;

  homophonic_digit_codec_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  hdc_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (check_failures),
    .results_due (results_due)
  );

  // Drive one transaction and hold it until accepted. A random gap may
  // come first; valid is only ever lowered here or in hold_until_drained.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DIG_W-1:0] row,
                           input logic [VAR_W-1:0] col, input logic [BYTE_W-1:0] b,
                           input logic [NUM_W-1:0] num, input logic [CHO_W-1:0] cho);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, cho, num, b, col, row};
    do @(posedge clk); while (!in_tready);
    if (op == OP_WRITE && row < DIGIT_ROWS) cipher_shadow[row * MAX_VARIANTS + col] = b;
    // dropped transactions do not count towards the random total
    if (op != OP_UNUSED && !(op == OP_WRITE && row >= DIGIT_ROWS)) random_items++;
  endtask

  task automatic store(input int row, input int col, input logic [BYTE_W-1:0] b);
    send_item(OP_WRITE, DIG_W'(row), VAR_W'(col), b, NUM_W'($urandom), $urandom);
  endtask

  task automatic encode(input logic [NUM_W-1:0] num, input logic [CHO_W-1:0] cho);
    send_item(OP_ENCODE, DIG_W'($urandom), VAR_W'($urandom), BYTE_W'($urandom), num, cho);
  endtask

  task automatic decode(input logic [BYTE_W-1:0] b);
    send_item(OP_DECODE, DIG_W'($urandom), VAR_W'($urandom), b, NUM_W'($urandom), $urandom);
  endtask

  // an operation code the block must drop
  task automatic send_unused();
    send_item(OP_UNUSED, DIG_W'($urandom), VAR_W'($urandom), BYTE_W'($urandom),
              NUM_W'($urandom), $urandom);
  endtask

  function automatic int unsigned decimal_span(input int unsigned d);
    int unsigned s;
    s = 1;
    repeat (d) s = s * 10;
    return s;
  endfunction

  // random variant word whose used slices are all legal
  function automatic logic [CHO_W-1:0] legal_choices();
    logic [CHO_W-1:0] cho;
    cho = $urandom;
    for (int i = 0; i < cur_digits; i++)
      cho[4*i +: 4] = VAR_W'($urandom_range(0, cur_letters - 1));
    return cho;
  endfunction

  // a byte that matches no entry in the variant columns in use
  function automatic logic [BYTE_W-1:0] stray_byte();
    logic [BYTE_W-1:0] b;
    bit               hit;
    b = BYTE_W'($urandom);
    for (int n = 0; n < 256; n++) begin
      hit = 1'b0;
      for (int r = 0; r < DIGIT_ROWS; r++)
        for (int c = 0; c < cur_letters; c++)
          if (cipher_shadow[r * MAX_VARIANTS + c] == b) hit = 1'b1;
      if (!hit) return b;
      b = b + 1'b1;
    end
    return b;
  endfunction

  // send good bytes of random digits, optionally broken by a stray byte
  task automatic decode_group(input int unsigned good, input bit broken);
    repeat (good)
      decode(cipher_shadow[$urandom_range(0, DIGIT_ROWS - 1) * MAX_VARIANTS +
                           $urandom_range(0, cur_letters - 1)]);
    if (broken) decode(stray_byte());
  endtask

  // hold the sender until every expected result has arrived
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic drain_results();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers while the block is idle
  task automatic set_codec(input logic [CFG_DATA_W-1:0] d_raw,
                           input logic [CFG_DATA_W-1:0] l_raw);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIGITS;
    cfg_wdata <= d_raw;
    @(posedge clk);
    cfg_index <= CFG_LETTERS;
    cfg_wdata <= l_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_digits  = (d_raw[3:0] == 0) ? 1 : ((d_raw[3:0] > MAX_DIGITS) ? MAX_DIGITS : d_raw[3:0]);
    cur_letters = (l_raw == 0) ? 1 : ((l_raw > MAX_VARIANTS) ? MAX_VARIANTS : l_raw);
  endtask

  // Result side: accept by default, stall in random bursts while idling is on.
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] d_raw, l_raw;
    logic [CHO_W-1:0]      cho;
    int                    pick, phase_goal, slot;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every entry before anything reads the table, then plant a byte
    // shared by digit 0 and digit 9 so that the lower digit must win.
    for (int r = 0; r < DIGIT_ROWS; r++)
      for (int c = 0; c < MAX_VARIANTS; c++) store(r, c, BYTE_W'($urandom));
    store(9, 0, cipher_shadow[0]);

    // Directed corners at the reset setting of one digit, one letter.
    encode(27'd0, '0);
    encode(27'd9, 32'hFFFF_FFF0);       // unused slices must be ignored
    encode(27'd10, '0);                 // number too large
    encode(27'h7FF_FFFF, '0);           // largest number field
    encode(27'd5, 32'h0000_0001);       // variant outside letters in use
    decode(cipher_shadow[9 * MAX_VARIANTS]);  // duplicate resolves to digit 0
    decode(stray_byte());               // unmatched byte
    store(12, 15, 8'hAA);               // row out of range, dropped
    store(3, 0, 8'h00);
    store(7, 0, 8'hFF);
    decode(8'h00);
    decode(8'hFF);
    send_unused();

    set_codec(CFG_DATA_W'(MAX_DIGITS), CFG_DATA_W'(MAX_VARIANTS));
    encode(27'd99_999_999, 32'hFFFF_FFFF);
    encode(27'd100_000_000, '0);
    decode_group(MAX_DIGITS, 1'b0);
    decode_group(3, 1'b1);              // broken group restarts
    decode_group(MAX_DIGITS, 1'b0);

    // Shrink the count mid-group: the next match must emit at once.
    set_codec(5'd4, 5'd3);
    decode_group(3, 1'b0);
    set_codec(5'd2, 5'd3);
    decode_group(1, 1'b0);

    // Random phases; the first five settings cover the clamped extremes.
    random_items = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin d_raw = CFG_DATA_W'(MAX_DIGITS); l_raw = CFG_DATA_W'(MAX_VARIANTS); end
        1: begin d_raw = 5'd1;  l_raw = 5'd1;  end
        2: begin d_raw = 5'h1F; l_raw = 5'h1F; end
        3: begin d_raw = 5'd0;  l_raw = 5'd0;  end
        4: begin d_raw = 5'd3;  l_raw = 5'd5;  end
        default: begin d_raw = CFG_DATA_W'($urandom); l_raw = CFG_DATA_W'($urandom); end
      endcase
      set_codec(d_raw, l_raw);
      idling_on  = (phase == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      phase_goal = RANDOM_ITEMS * (phase + 1) / PHASES;
      while (random_items < phase_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          encode(NUM_W'($urandom_range(0, decimal_span(cur_digits) - 1)), legal_choices());
        end else if (pick < 58) begin
          decode_group(cur_digits, 1'b0);
        end else if (pick < 66) begin
          decode_group($urandom_range(0, cur_digits - 1), 1'b1);
        end else if (pick < 74) begin
          store($urandom_range(0, DIGIT_ROWS - 1), $urandom_range(0, MAX_VARIANTS - 1),
                BYTE_W'($urandom));
        end else if (pick < 80) begin
          encode(NUM_W'($urandom_range(decimal_span(cur_digits), 32'h07FF_FFFF)), $urandom);
        end else if (pick < 87 && cur_letters < MAX_VARIANTS) begin
          cho  = legal_choices();
          slot = $urandom_range(0, cur_digits - 1);
          cho[4*slot +: 4] = VAR_W'($urandom_range(cur_letters, MAX_VARIANTS - 1));
          encode(NUM_W'($urandom_range(0, decimal_span(cur_digits) - 1)), cho);
        end else if (pick < 92) begin
          decode(stray_byte());
        end else if (pick < 96) begin
          send_unused();
        end else begin
          store($urandom_range(DIGIT_ROWS, 15), $urandom, BYTE_W'($urandom));
        end
        // now and then let the block run dry before going on
        if ($urandom_range(0, 39) == 0) hold_until_drained();
      end
    end

    drain_results();
    if (check_failures == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
